### rtl/core/ppd_pkg.sv
// Shared types and constants for the positional PID controller with deadband.
// Holds the sample/result beat structs, the config struct and register codes.
// No dependencies.
`default_nettype none

package ppd_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int DRIVE_WIDTH = 17;
	localparam int GAIN_WIDTH  = 16;
	localparam int LIMIT_WIDTH = 16;
	localparam int DB_WIDTH    = 8;
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 5;
	localparam int REG_IDX_WIDTH  = APB_ADDR_WIDTH - 2;

	localparam logic [DB_WIDTH-1:0] DEADBAND_RESET = 8'd5;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_DEADBAND       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] target;
		logic signed [DATA_WIDTH-1:0] measured;
	} sample_t;

	typedef struct packed {
		logic signed [DRIVE_WIDTH-1:0] drive;
		logic                          in_deadband;
	} result_t;

	typedef struct packed {
		logic signed [GAIN_WIDTH-1:0] prop_gain;
		logic signed [GAIN_WIDTH-1:0] integ_gain;
		logic signed [GAIN_WIDTH-1:0] deriv_gain;
		logic [LIMIT_WIDTH-1:0]       integral_limit;
		logic [LIMIT_WIDTH-1:0]       output_limit;
		logic [DB_WIDTH-1:0]          deadband;
	} ppd_cfg_t;

endpackage

`default_nettype wire

### rtl/core/positional_pid_deadband.sv
// Top level of the positional PID controller with deadband and APB config.
// Depends on ppd_pkg, ppd_regs and ppd_terms.
//
//   beat        handshake              payload
//   sample in   in_valid / in_stall    in_data  (target, measured)
//   result out  out_valid / out_stall  out_data (drive, in_deadband)
//   config      APB psel/penable       paddr, pwdata, prdata
//
// One sample per cycle while the output is not stalled; each result is registered.
// The input register feeds one combinational pass (error, deadband test, saturating
// accumulator update, three gain products and clamps) into the result register.
// Reset clears the accumulator, previous error and all valid bits.
// A stalled output holds; the input register still fills a bubble, then stalls.
`default_nettype none

module positional_pid_deadband #(
	parameter int ACC_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  ppd_pkg::sample_t                          in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output ppd_pkg::result_t                          out_data,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [ppd_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [ppd_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic      [ppd_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                      pready
);
	import ppd_pkg::*;

	localparam int EW  = DATA_WIDTH + 1;
	localparam int DEW = DATA_WIDTH + 2;
	localparam int SW  = ((ACC_WIDTH > EW) ? ACC_WIDTH : EW) + 1;

	ppd_cfg_t cfg;

	sample_t                     in_s1;
	logic                        valid_s1;
	result_t                     out_data_q;
	logic                        out_valid_q;

	logic signed [ACC_WIDTH-1:0] error_sum_q;
	logic signed [EW-1:0]        prev_error_q;

	logic                        en_out;
	logic                        en_s1;

	logic signed [EW-1:0]        err;
	logic signed [DEW-1:0]       err_x;
	logic signed [DEW-1:0]       db_x;
	logic                        in_db;
	logic signed [SW-1:0]        acc_sum;
	logic signed [SW-1:0]        acc_max;
	logic signed [SW-1:0]        acc_min;
	logic signed [ACC_WIDTH-1:0] acc_next;
	logic signed [DEW-1:0]       derr;
	logic signed [DRIVE_WIDTH-1:0] drive;

	ppd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// advance a stage when the one after it can take its beat
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s1    = !valid_s1 || en_out;
	assign in_stall = !en_s1;

	// error, deadband and accumulator
	assign err   = EW'(in_s1.target) - EW'(in_s1.measured);
	assign err_x = DEW'(err);
	assign db_x  = DEW'({1'b0, cfg.deadband});
	assign in_db = (err_x < db_x) && (err_x > -db_x);

	assign acc_sum = SW'(error_sum_q) + SW'(err);
	assign acc_max = SW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
	assign acc_min = ~acc_max;

	always_comb begin
		if (acc_sum > acc_max) begin
			acc_next = acc_max[ACC_WIDTH-1:0];
		end else if (acc_sum < acc_min) begin
			acc_next = acc_min[ACC_WIDTH-1:0];
		end else begin
			acc_next = acc_sum[ACC_WIDTH-1:0];
		end
	end

	assign derr = err_x - DEW'(prev_error_q);

	// products and clamps
	ppd_terms #(
		.ACC_WIDTH      (ACC_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_terms (
		.err   (err),
		.acc   (acc_next),
		.derr  (derr),
		.cfg   (cfg),
		.drive (drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_out) begin
				out_valid_q <= valid_s1;
				// freeze state for a beat inside the deadband
				if (valid_s1 && !in_db) begin
					error_sum_q  <= acc_next;
					prev_error_q <= err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			in_s1 <= in_data;
		end
		if (en_out && valid_s1) begin
			out_data_q.drive       <= in_db ? '0 : drive;
			out_data_q.in_deadband <= in_db;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### rtl/core/ppd_regs.sv
// APB configuration registers of the PID controller: gains, limits, deadband.
// Depends on ppd_pkg for the config struct and register codes.
`default_nettype none

module ppd_regs (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [ppd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
	input  wire logic [ppd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
	output logic      [ppd_pkg::APB_DATA_WIDTH-1:0]    prdata,
	output ppd_pkg::ppd_cfg_t                          cfg
);
	import ppd_pkg::*;

	ppd_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.integral_limit <= '0;
			cfg_q.output_limit   <= '0;
			cfg_q.deadband       <= DEADBAND_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN:     cfg_q.integ_gain     <= pwdata[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata[GAIN_WIDTH-1:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= pwdata[LIMIT_WIDTH-1:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= pwdata[LIMIT_WIDTH-1:0];
				REG_DEADBAND:       cfg_q.deadband       <= pwdata[DB_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:      prdata = APB_DATA_WIDTH'(unsigned'(cfg_q.prop_gain));
			REG_INTEG_GAIN:     prdata = APB_DATA_WIDTH'(unsigned'(cfg_q.integ_gain));
			REG_DERIV_GAIN:     prdata = APB_DATA_WIDTH'(unsigned'(cfg_q.deriv_gain));
			REG_INTEGRAL_LIMIT: prdata = APB_DATA_WIDTH'(cfg_q.integral_limit);
			REG_OUTPUT_LIMIT:   prdata = APB_DATA_WIDTH'(cfg_q.output_limit);
			REG_DEADBAND:       prdata = APB_DATA_WIDTH'(cfg_q.deadband);
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/core/ppd_terms.sv
// Gain products, integral clamp, term sum and output clamp of the PID step.
// Purely combinational; depends on ppd_pkg for the config struct.
`default_nettype none

module ppd_terms #(
	parameter int ACC_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  wire logic signed [ppd_pkg::DATA_WIDTH:0]      err,
	input  wire logic signed [ACC_WIDTH-1:0]              acc,
	input  wire logic signed [ppd_pkg::DATA_WIDTH+1:0]    derr,
	input  ppd_pkg::ppd_cfg_t                             cfg,
	output logic signed [ppd_pkg::DRIVE_WIDTH-1:0]        drive
);
	import ppd_pkg::*;

	localparam int PW  = DATA_WIDTH + 1 + GAIN_WIDTH;
	localparam int IPW = ACC_WIDTH + GAIN_WIDTH;
	localparam int DPW = DATA_WIDTH + 2 + GAIN_WIDTH;
	localparam int TW  = ((IPW > DPW) ? IPW : DPW) + 2;

	logic signed [PW-1:0]  p_prod;
	logic signed [IPW-1:0] i_prod;
	logic signed [DPW-1:0] d_prod;
	logic signed [IPW-1:0] i_sh;
	logic signed [IPW-1:0] ilim;
	logic signed [IPW-1:0] i_cl;
	logic signed [TW-1:0]  total;
	logic signed [TW-1:0]  olim;
	logic signed [TW-1:0]  total_cl;

	assign p_prod = cfg.prop_gain * err;
	assign i_prod = cfg.integ_gain * acc;
	assign d_prod = cfg.deriv_gain * derr;

	// arithmetic shift floors, matching the fixed-point scaling
	assign i_sh = i_prod >>> GAIN_FRAC_BITS;
	assign ilim = IPW'({1'b0, cfg.integral_limit});

	always_comb begin
		if (i_sh > ilim) begin
			i_cl = ilim;
		end else if (i_sh < -ilim) begin
			i_cl = -ilim;
		end else begin
			i_cl = i_sh;
		end
	end

	assign total = TW'(p_prod >>> GAIN_FRAC_BITS) + TW'(i_cl)
		+ TW'(d_prod >>> GAIN_FRAC_BITS);
	assign olim = TW'({1'b0, cfg.output_limit});

	always_comb begin
		if (total > olim) begin
			total_cl = olim;
		end else if (total < -olim) begin
			total_cl = -olim;
		end else begin
			total_cl = total;
		end
	end

	assign drive = total_cl[DRIVE_WIDTH-1:0];

endmodule

`default_nettype wire

### rtl/core/ppd_checker.sv
// Port-level checks for the PID controller, bound to the top level.
// Depends on ppd_pkg for the result beat type.
`default_nettype none

module ppd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input ppd_pkg::result_t out_data,
	input wire logic        pready
);
	import ppd_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// input only backs up when the output is full and stalled
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled with a free output");

	// a deadband result carries zero drive
	a_deadband_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_deadband |-> out_data.drive == '0)
		else $error("deadband result with nonzero drive");

	// no result beat appears from an empty output and an idle input without a sample
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_valid ##1 !out_valid |=> !out_valid || $past(in_valid, 2)
		|| $past(in_valid))
		else $error("result beat without a sample");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind positional_pid_deadband ppd_checker u_ppd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.pready    (pready)
);

`default_nettype wire

### test/positional_pid_deadband_test.sv
// Testbench for positional_pid_deadband: sends sample beats, programs the gains and limits
// over APB, predicts every result beat with its own fixed-point PID model and checks them in order.
// Depends on ppd_pkg and the positional_pid_deadband RTL.
module positional_pid_deadband_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppd_pkg::*;

	localparam int ACC_BITS = 32;
	localparam int FRAC_BITS = 8;
	localparam longint ACC_MAX = (longint'(1) << (ACC_BITS - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int RANDOM_SETTINGS = 8;
	localparam int SAMPLES_PER_SETTING = 195;
	localparam int WINDUP_SAMPLES = 60;
	localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	result_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic pready;

	// model of the register file and controller state
	ppd_cfg_t cfg_model;
	longint err_sum_model;
	longint last_err_model;
	result_t pending_results[$];

	int mismatches = 0;
	int samples_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int stall_mode = 0;
	int mode_left = 0;

	always #5 clk = ~clk;

	positional_pid_deadband #(
		.ACC_WIDTH(ACC_BITS),
		.GAIN_FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// one controller step; updates the model state unless the error sits in the deadband
	function automatic result_t pid_step(sample_t s);
		longint err, mag, kp, ki, kd, p_term, i_term, d_term, total;
		result_t r;
		r = '0;
		err = longint'($signed(s.target)) - longint'($signed(s.measured));
		mag = (err < 0) ? -err : err;
		if (mag < longint'(cfg_model.deadband)) begin
			r.in_deadband = 1'b1;
			return r;
		end
		err_sum_model = err_sum_model + err;
		if (err_sum_model > ACC_MAX) begin
			err_sum_model = ACC_MAX;
		end else if (err_sum_model < ACC_MIN) begin
			err_sum_model = ACC_MIN;
		end
		kp = longint'($signed(cfg_model.prop_gain));
		ki = longint'($signed(cfg_model.integ_gain));
		kd = longint'($signed(cfg_model.deriv_gain));
		p_term = (kp * err) >>> FRAC_BITS;
		i_term = (ki * err_sum_model) >>> FRAC_BITS;
		d_term = (kd * (err - last_err_model)) >>> FRAC_BITS;
		i_term = clamp_mag(i_term, longint'(cfg_model.integral_limit));
		total = clamp_mag(p_term + i_term + d_term, longint'(cfg_model.output_limit));
		last_err_model = err;
		r.drive = total[DRIVE_WIDTH-1:0];
		return r;
	endfunction

	function automatic sample_t make_sample(int t, int m);
		sample_t s;
		s.target = t[DATA_WIDTH-1:0];
		s.measured = m[DATA_WIDTH-1:0];
		return s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// called at a rising edge; returns at the edge that took the beat, or after the gap
	task automatic send_sample(input sample_t s);
		int gap;
		in_data <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(pid_step(s));
		samples_sent++;
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 24);
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_WIDTH-1:0] idx,
			input logic [APB_DATA_WIDTH-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PROP_GAIN: cfg_model.prop_gain = value[GAIN_WIDTH-1:0];
			REG_INTEG_GAIN: cfg_model.integ_gain = value[GAIN_WIDTH-1:0];
			REG_DERIV_GAIN: cfg_model.deriv_gain = value[GAIN_WIDTH-1:0];
			REG_INTEGRAL_LIMIT: cfg_model.integral_limit = value[LIMIT_WIDTH-1:0];
			REG_OUTPUT_LIMIT: cfg_model.output_limit = value[LIMIT_WIDTH-1:0];
			REG_DEADBAND: cfg_model.deadband = value[DB_WIDTH-1:0];
			default: ;
		endcase
		// wait with the bus idle so the next setup phase does not collide with this one
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] kd, input logic [15:0] ilim, input logic [15:0] olim,
			input logic [7:0] db);
		reg_write(REG_PROP_GAIN, {16'h0, kp});
		reg_write(REG_INTEG_GAIN, {16'h0, ki});
		reg_write(REG_DERIV_GAIN, {16'h0, kd});
		reg_write(REG_INTEGRAL_LIMIT, {16'h0, ilim});
		reg_write(REG_OUTPUT_LIMIT, {16'h0, olim});
		reg_write(REG_DEADBAND, {24'h0, db});
		settings_used++;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 1024) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 2000));
			default: return 16'($urandom);
		endcase
	endfunction

	// reset settings: gains and limits zero, deadband 5
	task automatic test_deadband_edges;
		send_sample(make_sample(4, 0));
		send_sample(make_sample(0, 4));
		send_sample(make_sample(5, 0));
		send_sample(make_sample(0, 5));
		send_sample(make_sample(7, 7));
		drain();
	endtask

	task automatic test_extremes;
		program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'd0);
		send_sample(make_sample(32767, -32768));
		send_sample(make_sample(-32768, 32767));
		send_sample(make_sample(0, 0));
		send_sample(make_sample(-1, -1));
		send_sample(make_sample(32767, 32767));
		send_sample(make_sample(-32768, -32768));
		drain();
	endtask

	// zero limits: both zero force drive to zero while the state keeps moving, then a zero integral limit alone
	task automatic test_zero_limits;
		program_regs(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 8'd3);
		send_sample(make_sample(100, -100));
		send_sample(make_sample(-32768, 32767));
		send_sample(make_sample(1, 0));
		drain();
		program_regs(16'h0100, 16'h7FFF, 16'h0040, 16'h0000, 16'hFFFF, 8'd3);
		send_sample(make_sample(2000, -300));
		send_sample(make_sample(-50, 50));
		drain();
	endtask

	task automatic test_wide_deadband;
		program_regs(16'h0100, 16'h0010, 16'hFFC0, 16'd1000, 16'hFFFF, 8'd255);
		send_sample(make_sample(254, 0));
		send_sample(make_sample(0, 255));
		send_sample(make_sample(255, 0));
		send_sample(make_sample(0, 254));
		drain();
	endtask

	// writes to unmapped addresses must leave the settings alone
	task automatic test_unknown_registers;
		reg_write(REG_UNUSED_A, '1);
		reg_write(REG_UNUSED_B, '1);
		send_sample(make_sample(300, 0));
		send_sample(make_sample(-300, 0));
		drain();
	endtask

	// wind the integrator up with full-scale error back to back, then pull it back down
	task automatic test_windup;
		int extra;
		gaps_on = 1'b0;
		program_regs(16'hFFFD, 16'h0100, 16'd100, 16'hFFFF, 16'hFFFF, 8'd0);
		for (extra = 0; extra < WINDUP_SAMPLES; extra++)
			send_sample(make_sample(32767, -32768 + $urandom_range(0, 255)));
		for (extra = 0; extra < WINDUP_SAMPLES; extra++)
			send_sample(make_sample(-32768, 32767 - $urandom_range(0, 255)));
		gaps_on = 1'b1;
		drain();
	endtask

	task automatic test_random;
		int n, k, t, m, db;
		logic [7:0] db_set;
		for (n = 0; n < RANDOM_SETTINGS; n++) begin
			case ($urandom_range(0, 3))
				0: db_set = 8'd0;
				1: db_set = 8'd255;
				2: db_set = 8'($urandom_range(0, 31));
				default: db_set = 8'($urandom);
			endcase
			program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
				db_set);
			db = int'(cfg_model.deadband);
			for (k = 0; k < SAMPLES_PER_SETTING; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						// hover around the deadband edge
						t = int'($urandom);
						m = t - (int'($urandom_range(0, 2 * db + 4)) - (db + 2));
					end
					4, 5: begin
						t = int'($urandom_range(0, 8000)) - 4000;
						m = t - (int'($urandom_range(0, 4000)) - 2000);
					end
					default: begin
						t = int'($urandom);
						m = int'($urandom);
					end
				endcase
				send_sample(make_sample(t, m));
			end
			drain();
		end
	endtask

	// receiver stall pattern: free-running, mostly-open, mostly-stalled, or square wave
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(16, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= mode_left[2];
		endcase
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", $signed(out_data.drive), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.drive !== want.drive)
					report_mismatch("drive", $signed(out_data.drive), $signed(want.drive));
				if (out_data.in_deadband !== want.in_deadband)
					report_mismatch("in_deadband", out_data.in_deadband, want.in_deadband);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		cfg_model = '0;
		cfg_model.deadband = DEADBAND_RESET;
		err_sum_model = 0;
		last_err_model = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_deadband_edges();
		test_extremes();
		test_zero_limits();
		test_wide_deadband();
		test_unknown_registers();
		test_windup();
		test_random();
		$display("Checked %0d samples under %0d register settings, with deadband edges,",
			samples_sent, settings_used);
		$display("zero and full-scale limits, and integrator windup in both directions.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### positional_pid_deadband.f
rtl/core/ppd_pkg.sv
rtl/core/ppd_regs.sv
rtl/core/ppd_terms.sv
rtl/core/positional_pid_deadband.sv
rtl/core/ppd_checker.sv
test/positional_pid_deadband_test.sv
